// ===== rtl/nmea_pkg.sv =====
// Package: character codes, sentence kind codes and hex digit decode for the NMEA checker.
`timescale 1ns / 1ps

package nmea_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] kind_t;

  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_TAB    = 8'h09;

  // Three-letter sentence formatters, first letter in the high byte.
  localparam logic [23:0] FMT_GGA = 24'h474741;
  localparam logic [23:0] FMT_RMC = 24'h524D43;
  localparam logic [23:0] FMT_ZDA = 24'h5A4441;
  localparam logic [23:0] FMT_VTG = 24'h565447;

  localparam kind_t KIND_OTHER = 3'd0;
  localparam kind_t KIND_GGA   = 3'd1;
  localparam kind_t KIND_RMC   = 3'd2;
  localparam kind_t KIND_ZDA   = 3'd3;
  localparam kind_t KIND_VTG   = 3'd4;

  // Bit 4 set: not a hex digit. Otherwise bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_digit(input char_t c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

// ===== rtl/nmea_sentence_checker.sv =====
// Top level: NMEA 0183 sentence checksum and formatter checker on a byte stream.
`timescale 1ns / 1ps

// nmea_sentence_checker takes one text byte per input beat and emits one result
// beat for each LF that ends a sentence (a line whose first non-blank character
// is '$'). Lines that start with anything else are skipped silently up to LF, and
// CR is ignored everywhere. The result holds the XOR of the bytes between '$' and
// the last '*', the checksum given by the leading hex digits of the two bytes
// after that star, a frame_valid flag (a star followed by at least two bytes), a
// checksum_ok flag (frame_valid and both sums equal) and the sentence kind, read
// from the three characters before the first comma when that comma is the sixth
// character after '$'. Throughput is one byte per clock: all per-byte tracking is
// a single XOR and a few small compares on the line state registers, and the
// result sits in one output register. A new byte is taken whenever that register
// is empty or is being drained in the same cycle, so a stalled result only holds
// off input while the downstream side keeps out_tready low. The result beat
// appears in the cycle after the LF beat is accepted.
module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [0] checksum_ok, [1] frame_valid, [9:2] computed_sum,
  //            [17:10] given_sum, [23:18] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: [2:0] sentence_kind
  output logic [2:0]  out_tuser
);

  import nmea_pkg::*;

  // Line phase codes.
  localparam logic [1:0] PH_WAIT = 2'd0;  // before first non-blank char
  localparam logic [1:0] PH_SENT = 2'd1;  // inside a '$' sentence
  localparam logic [1:0] PH_SKIP = 2'd2;  // ignoring the rest of the line

  // Line state
  logic [1:0]  phase_r,     phase_nxt;
  logic [7:0]  run_xor_r,   run_xor_nxt;
  logic [7:0]  star_xor_r,  star_xor_nxt;
  logic        star_seen_r, star_seen_nxt;
  logic [1:0]  after_cnt_r, after_cnt_nxt;   // bytes after last star, sat. at 2
  logic [7:0]  hex_val_r,   hex_val_nxt;
  logic        hex_stop_r,  hex_stop_nxt;
  logic [2:0]  char_pos_r,  char_pos_nxt;    // position after '$', sat. at 7
  logic [23:0] fmt_r,       fmt_nxt;
  logic        fmt_done_r,  fmt_done_nxt;

  // Result register
  logic        out_valid_r;
  logic        ok_r, fv_r;
  logic [7:0]  comp_r, given_r;
  kind_t       kind_r;

  logic        in_fire;
  logic        res_fire;
  char_t       c;
  logic [4:0]  dig;
  logic [2:0]  pos;
  logic        res_fv;
  logic [7:0]  res_comp, res_given;
  kind_t       res_kind;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign dig       = hex_digit(c);
  assign pos       = (char_pos_r == 3'd7) ? 3'd7 : char_pos_r + 3'd1;

  // Result fields as seen at the LF beat.
  always_comb begin
    res_fv    = star_seen_r && (after_cnt_r == 2'd2);
    res_comp  = star_seen_r ? star_xor_r : 8'h00;
    res_given = star_seen_r ? hex_val_r  : 8'h00;
    res_kind  = KIND_OTHER;
    if (fmt_done_r) begin
      priority if (fmt_r == FMT_GGA) res_kind = KIND_GGA;
      else if (fmt_r == FMT_RMC)     res_kind = KIND_RMC;
      else if (fmt_r == FMT_ZDA)     res_kind = KIND_ZDA;
      else if (fmt_r == FMT_VTG)     res_kind = KIND_VTG;
      else                           res_kind = KIND_OTHER;
    end
  end

  // Per-byte line tracking.
  always_comb begin
    phase_nxt     = phase_r;
    run_xor_nxt   = run_xor_r;
    star_xor_nxt  = star_xor_r;
    star_seen_nxt = star_seen_r;
    after_cnt_nxt = after_cnt_r;
    hex_val_nxt   = hex_val_r;
    hex_stop_nxt  = hex_stop_r;
    char_pos_nxt  = char_pos_r;
    fmt_nxt       = fmt_r;
    fmt_done_nxt  = fmt_done_r;
    res_fire      = 1'b0;

    if (in_fire && c != CH_CR) begin
      if (c == CH_LF || (phase_r == PH_WAIT && c == CH_DOLLAR)) begin
        res_fire      = (c == CH_LF) && (phase_r == PH_SENT);
        phase_nxt     = (c == CH_LF) ? PH_WAIT : PH_SENT;
        run_xor_nxt   = 8'h00;
        star_xor_nxt  = 8'h00;
        star_seen_nxt = 1'b0;
        after_cnt_nxt = 2'd0;
        hex_val_nxt   = 8'h00;
        hex_stop_nxt  = 1'b0;
        char_pos_nxt  = 3'd0;
        fmt_nxt       = 24'h0;
        fmt_done_nxt  = 1'b0;
      end else if (phase_r == PH_WAIT) begin
        if (c != CH_SPACE && c != CH_TAB) begin
          phase_nxt = PH_SKIP;
        end
      end else if (phase_r == PH_SENT) begin
        // formatter tracking until the first comma or position six
        if (!fmt_done_r) begin
          char_pos_nxt = pos;
          if (c == CH_COMMA) begin
            fmt_done_nxt = 1'b1;
            if (pos != 3'd6) fmt_nxt = 24'h0;
          end else if (pos >= 3'd3 && pos <= 3'd5) begin
            fmt_nxt = {fmt_r[15:0], c};
          end else if (pos >= 3'd6) begin
            fmt_done_nxt = 1'b1;
            fmt_nxt      = 24'h0;
          end
        end
        // checksum tracking; the star itself enters the running XOR
        if (c == CH_STAR) begin
          star_xor_nxt  = run_xor_r;
          star_seen_nxt = 1'b1;
          after_cnt_nxt = 2'd0;
          hex_val_nxt   = 8'h00;
          hex_stop_nxt  = 1'b0;
        end else if (star_seen_r && after_cnt_r != 2'd2) begin
          if (!hex_stop_r && !dig[4]) begin
            hex_val_nxt = {hex_val_r[3:0], dig[3:0]};
          end else begin
            hex_stop_nxt = 1'b1;
          end
          after_cnt_nxt = after_cnt_r + 2'd1;
        end
        run_xor_nxt = run_xor_r ^ c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      run_xor_r   <= 8'h00;
      star_xor_r  <= 8'h00;
      star_seen_r <= 1'b0;
      after_cnt_r <= 2'd0;
      hex_val_r   <= 8'h00;
      hex_stop_r  <= 1'b0;
      char_pos_r  <= 3'd0;
      fmt_r       <= 24'h0;
      fmt_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      run_xor_r   <= run_xor_nxt;
      star_xor_r  <= star_xor_nxt;
      star_seen_r <= star_seen_nxt;
      after_cnt_r <= after_cnt_nxt;
      hex_val_r   <= hex_val_nxt;
      hex_stop_r  <= hex_stop_nxt;
      char_pos_r  <= char_pos_nxt;
      fmt_r       <= fmt_nxt;
      fmt_done_r  <= fmt_done_nxt;
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; loads only when the slot is free or draining.
  always_ff @(posedge clk) begin
    if (res_fire) begin
      fv_r    <= res_fv;
      ok_r    <= res_fv && (res_comp == res_given);
      comp_r  <= res_comp;
      given_r <= res_given;
      kind_r  <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, given_r, comp_r, fv_r, ok_r};
  assign out_tuser  = kind_r;

endmodule

// ===== rtl/nmea_checker_sva.sv =====
// Checker: port-level assertions for nmea_sentence_checker, with its bind.
`timescale 1ns / 1ps

module nmea_checker_sva (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [2:0]  out_tuser
);

  import nmea_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A new result follows an accepted LF beat.
  a_res_after_lf: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata == CH_LF))
    else $error("result beat without a preceding LF");

  // Input backpressure only while a result is stalled.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input held off with no stalled result");

  // checksum_ok implies frame_valid.
  a_ok_fv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("checksum_ok without frame_valid");

  // Unused kind codes never appear.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_VTG)
    else $error("sentence kind out of range");

endmodule

bind nmea_sentence_checker nmea_checker_sva u_nmea_checker_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_nmea_sentence_checker.sv =====
// Testbench top: streams NMEA text into the sentence checker and checks every result beat.
`timescale 1ns / 1ps

// Stimulus is a queue of text bytes that the main initial block fills phase by phase.
// A clocked driver offers the bytes on the in_ channel. Every accepted byte also goes
// into a byte-level line tracker in this module, and each LF that closes a sentence
// queues one expected verdict. A clocked monitor pops that queue for each out_ beat
// and compares the fields one by one. Both sides idle at random. In one phase the
// receiver also holds off for a long stretch, which backs the block up into its input.
module tb_nmea_sentence_checker;
  import nmea_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT     = 2'd0,
    PH_SENTENCE = 2'd1,
    PH_SKIP     = 2'd2
  } line_phase_e;

  // Same order as the result fields; packed, so the first member is the MSB.
  typedef struct packed {
    logic       checksum_ok;
    logic       frame_valid;
    logic [7:0] computed_sum;
    logic [7:0] given_sum;
    kind_t      sentence_kind;
  } verdict_t;

  localparam int HOLD_CYCLES = 300;  // long receiver stall, in clocks
  localparam int TAIL_CYCLES = 8;    // settle time after the last result
  localparam int PHASE_BYTES = 650;  // minimum random bytes per random phase

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // in_tdata: [7:0] data_byte
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  // out_tdata: [0] checksum_ok, [1] frame_valid, [9:2] computed_sum,
  //            [17:10] given_sum, [23:18] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  // out_tuser: [2:0] sentence_kind
  logic [2:0]  out_tuser;

  char_t    text_bytes[$];       // bytes still to be offered
  verdict_t expected_verdicts[$];
  int       error_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;  // bumped by the sequencer, served by the monitor
  int holds_served = 0;
  int hold_left = 0;

  // Line tracker state, one copy of what the block keeps per line.
  line_phase_e ln_phase = PH_WAIT;
  logic [7:0]  ln_xor = '0;
  logic [7:0]  ln_xor_at_star = '0;
  logic        ln_star = 1'b0;
  logic [1:0]  ln_after_star = '0;
  logic [7:0]  ln_hex = '0;
  logic        ln_hex_stop = 1'b0;
  logic [2:0]  ln_pos = '0;
  logic [23:0] ln_fmt = '0;
  logic        ln_fmt_done = 1'b0;

  nmea_sentence_checker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- line tracker

  // Bit 4 flags a non-hex character.
  function automatic logic [4:0] nibble_of(input char_t c);
    if (c >= "0" && c <= "9") return 5'(c - 8'h30);
    if (c >= "A" && c <= "F") return 5'(c - 8'h37);
    if (c >= "a" && c <= "f") return 5'(c - 8'h57);
    return 5'h10;
  endfunction

  task automatic reset_line();
    ln_xor = '0;
    ln_xor_at_star = '0;
    ln_star = 1'b0;
    ln_after_star = '0;
    ln_hex = '0;
    ln_hex_stop = 1'b0;
    ln_pos = '0;
    ln_fmt = '0;
    ln_fmt_done = 1'b0;
  endtask

  task automatic track_byte(input char_t c);
    verdict_t   v;
    logic [4:0] nib;
    logic [2:0] pos;
    if (c == CH_CR) return;  // CR is invisible everywhere
    if (c == CH_LF) begin
      if (ln_phase == PH_SENTENCE) begin
        v.frame_valid   = ln_star && (ln_after_star == 2'd2);
        v.computed_sum  = ln_star ? ln_xor_at_star : 8'h00;
        v.given_sum     = ln_star ? ln_hex : 8'h00;
        v.sentence_kind = KIND_OTHER;
        if (ln_fmt_done) begin
          case (ln_fmt)
            FMT_GGA: v.sentence_kind = KIND_GGA;
            FMT_RMC: v.sentence_kind = KIND_RMC;
            FMT_ZDA: v.sentence_kind = KIND_ZDA;
            FMT_VTG: v.sentence_kind = KIND_VTG;
            default: v.sentence_kind = KIND_OTHER;
          endcase
        end
        v.checksum_ok = v.frame_valid && (v.computed_sum == v.given_sum);
        expected_verdicts.insert(expected_verdicts.size(), v);
      end
      ln_phase = PH_WAIT;
      reset_line();
    end else if (ln_phase == PH_WAIT) begin
      if (c != CH_SPACE && c != CH_TAB) begin
        if (c == CH_DOLLAR) begin
          reset_line();
          ln_phase = PH_SENTENCE;
        end else begin
          ln_phase = PH_SKIP;
        end
      end
    end else if (ln_phase == PH_SENTENCE) begin
      // Formatter: chars 3..5 after '$', valid only if the first comma is char 6.
      if (!ln_fmt_done) begin
        pos = (ln_pos == 3'd7) ? 3'd7 : ln_pos + 3'd1;
        ln_pos = pos;
        if (c == CH_COMMA) begin
          ln_fmt_done = 1'b1;
          if (pos != 3'd6) ln_fmt = '0;
        end else if (pos >= 3'd3 && pos <= 3'd5) begin
          ln_fmt = {ln_fmt[15:0], c};
        end else if (pos >= 3'd6) begin
          ln_fmt_done = 1'b1;
          ln_fmt = '0;
        end
      end
      // Checksum: each star restarts the given-sum capture.
      if (c == CH_STAR) begin
        ln_xor_at_star = ln_xor;
        ln_star = 1'b1;
        ln_after_star = '0;
        ln_hex = '0;
        ln_hex_stop = 1'b0;
      end else if (ln_star && ln_after_star < 2'd2) begin
        nib = nibble_of(c);
        if (!ln_hex_stop && !nib[4]) ln_hex = {ln_hex[3:0], nib[3:0]};
        else ln_hex_stop = 1'b1;
        ln_after_star = ln_after_star + 2'd1;
      end
      ln_xor = ln_xor ^ c;
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input char_t b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(char_t'(s[i]));
  endtask

  function automatic char_t hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  task automatic push_hex(input logic [7:0] b, input bit lower);
    add_byte(hex_char(b[7:4], lower));
    add_byte(hex_char(b[3:0], lower));
  endtask

  function automatic logic [7:0] text_xor(input string s);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  function automatic char_t upper_char();
    return char_t'(8'h41 + $urandom_range(0, 25));
  endfunction

  // Mostly NMEA-like field content; now and then any printable, star and dollar included.
  function automatic char_t field_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return char_t'(8'h30 + $urandom_range(0, 9));
    if (pick < 70) return upper_char();
    if (pick < 80) return ".";
    if (pick < 85) return "-";
    if (pick < 93) return char_t'(8'h61 + $urandom_range(0, 25));
    return char_t'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic queue_random_line();
    char_t       body[$];
    logic [7:0]  sum;
    logic [23:0] fmt;
    int          style, shift, tail;
    bit          lower;
    style = $urandom_range(0, 99);
    // Raw noise: any byte value, LF included by chance.
    if (style < 8) begin
      repeat ($urandom_range(1, 12)) add_byte(char_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) add_byte(CH_LF);
      return;
    end
    // Line that does not start with '$': skipped up to LF.
    if (style < 16) begin
      repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      add_byte(upper_char());
      repeat ($urandom_range(0, 15)) add_byte(field_char());
      add_byte(CH_LF);
      return;
    end

    body.insert(body.size(), upper_char());
    body.insert(body.size(), upper_char());
    case ($urandom_range(0, 5))
      0: fmt = FMT_GGA;
      1: fmt = FMT_RMC;
      2: fmt = FMT_ZDA;
      3: fmt = FMT_VTG;
      default: fmt = {upper_char(), upper_char(), upper_char()};
    endcase
    body.insert(body.size(), fmt[23:16]);
    body.insert(body.size(), fmt[15:8]);
    shift = $urandom_range(0, 9);
    if (shift != 0) body.insert(body.size(), fmt[7:0]);  // shift 0: comma lands one early
    if (shift == 1) body.insert(body.size(), upper_char());  // one late
    repeat ($urandom_range(0, 6)) begin
      body.insert(body.size(), CH_COMMA);
      repeat ($urandom_range(0, 6)) body.insert(body.size(), field_char());
    end

    sum = '0;
    foreach (body[i]) sum ^= body[i];

    repeat ($urandom_range(0, 2)) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    add_byte(CH_DOLLAR);
    foreach (body[i]) begin
      if ($urandom_range(0, 29) == 0) add_byte(CH_CR);
      add_byte(body[i]);
    end

    lower = $urandom_range(0, 1);
    tail = $urandom_range(0, 9);
    if (tail <= 5) begin
      add_byte(CH_STAR);
      push_hex(sum, lower);
    end else if (tail == 6) begin
      add_byte(CH_STAR);
      push_hex(8'($urandom_range(0, 255)), lower);
    end else if (tail == 7) begin
      add_byte(CH_STAR);
      add_byte(hex_char(sum[7:4], lower));
    end else if (tail == 8) begin
      add_byte(CH_STAR);
      add_byte(field_char());
      add_byte(field_char());
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) add_byte(field_char());
    end
    if ($urandom_range(0, 39) != 0) begin  // rarely run two lines together
      if ($urandom_range(0, 1)) add_byte(CH_CR);
      add_byte(CH_LF);
    end
  endtask

  task automatic queue_random_phase(input int n_bytes);
    int start;
    start = text_bytes.size();
    while (text_bytes.size() - start < n_bytes) queue_random_line();
  endtask

  // Sender stays quiet until every byte is taken and every verdict has come back.
  task automatic wait_until_drained();
    @(posedge clk);
    while (text_bytes.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
    end else begin
      if (in_tvalid && in_tready) track_byte(in_tdata);
      // New beat only once the current one is gone; valid never dips while held.
      if (!in_tvalid || in_tready) begin
        if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= text_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_verdict(input verdict_t got);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $error("unexpected result beat: out_tdata=%h out_tuser=%h", out_tdata, out_tuser);
      error_count++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.checksum_ok !== want.checksum_ok) begin
      $error("checksum_ok: expected %0d, actual %0d", want.checksum_ok, got.checksum_ok);
      error_count++;
    end
    if (got.frame_valid !== want.frame_valid) begin
      $error("frame_valid: expected %0d, actual %0d", want.frame_valid, got.frame_valid);
      error_count++;
    end
    if (got.computed_sum !== want.computed_sum) begin
      $error("computed_sum: expected %h, actual %h", want.computed_sum, got.computed_sum);
      error_count++;
    end
    if (got.given_sum !== want.given_sum) begin
      $error("given_sum: expected %h, actual %h", want.given_sum, got.given_sum);
      error_count++;
    end
    if (got.sentence_kind !== want.sentence_kind) begin
      $error("sentence_kind: expected %0d, actual %0d", want.sentence_kind, got.sentence_kind);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_verdict({out_tdata[0], out_tdata[1], out_tdata[9:2], out_tdata[17:10], out_tuser});
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        out_tready   <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct <= 20;
    recv_idle_pct <= 46;

    // Directed lines.
    push_text("\n");                                      // LF with no sentence open
    add_byte(8'h00);                                      // skipped line, byte extremes
    add_byte(8'hFF);
    push_text("\n");
    push_text(" \t$GPGGA,*");                             // blanks, GGA, good sum, CR
    push_hex(text_xor("GPGGA,"), 1'b0);
    add_byte(CH_CR);
    add_byte(CH_LF);
    push_text("$A$,");                                    // second '$', early comma, non-hex
    add_byte(CH_CR);
    push_text("*1z\n");
    push_text("$*\n");                                    // star with nothing after it
    wait_until_drained();

    // Phase 1: long receiver stall while the sender keeps offering bytes.
    queue_random_phase(PHASE_BYTES);
    hold_requests = hold_requests + 1;
    wait_until_drained();

    send_idle_pct <= 46;
    recv_idle_pct <= 20;
    queue_random_phase(PHASE_BYTES);
    wait_until_drained();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    queue_random_phase(PHASE_BYTES);
    wait_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
